// ===== design/pgu_pkg.sv =====
`default_nettype none

package pgu_pkg;

  localparam int TableDepthDefault = 257;
  localparam int QueueDepthDefault = 8;
  localparam int MaxRun            = 4;

  localparam logic [15:0] UnityGain = 16'h3fff;
  localparam logic [23:0] GainDiv   = 24'd16383;
  localparam logic [15:0] NegLimit  = 16'hff80;
  localparam logic [15:0] PosLimit  = 16'h007f;

  localparam logic [1:0] OsTwo  = 2'd1;
  localparam logic [1:0] OsFour = 2'd2;

  typedef enum logic [1:0] {
    CFG_VOLUME,
    CFG_SIXTEEN_BIT,
    CFG_STEREO,
    CFG_OVERSAMPLE
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] volume;
    logic        sixteen_bit;
    logic        stereo;
    logic [1:0]  oversample_mode;
  } cfg_t;

  typedef struct packed {
    logic [15:0] right;
    logic [15:0] left;
  } pair_t;

  // Each half is truncated toward zero; eight-bit mode wraps to its low byte.
  function automatic logic [15:0] pcm_mid(input logic [15:0] a, input logic [15:0] b,
                                          input logic sixteen);
    logic [16:0] ha;
    logic [16:0] hb;
    logic [16:0] sum;
    ha  = 17'($signed({a[15], a} + 17'(a[15])) >>> 1);
    hb  = 17'($signed({b[15], b} + 17'(b[15])) >>> 1);
    sum = ha + hb;
    if (sixteen) begin
      return sum[15:0];
    end
    return {{8{sum[7]}}, sum[7:0]};
  endfunction

endpackage

`default_nettype wire

// ===== design/pcm_gain_and_linear_upsampler_core.sv =====
// One result per cycle while out_tready does not stall the output. A sample item yields
// 1, 2 or 4 results for 1x, 2x or 4x upsampling; table items yield no result.
// Reset (rst_n low, synchronous) clears the pipeline, the queue and the last samples and
// sets volume 0, 16-bit, stereo and 1x. Gain table contents are not cleared.
`default_nettype none

module pcm_gain_and_linear_upsampler_core
  import pgu_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDefault,
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,  // left_sample, right_sample, table_index, table_value
  input  wire logic        in_tuser,  // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata, // left_out, right_out
  output logic             out_tlast
);

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  q_push;
  pair_t q_din;
  logic  q_pop;
  logic  q_valid;
  pair_t q_dout;
  logic  q_full;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_VOLUME:      cfg_nxt.volume          = cfg_data;
        CFG_SIXTEEN_BIT: cfg_nxt.sixteen_bit     = cfg_data[0];
        CFG_STEREO:      cfg_nxt.stereo          = cfg_data[0];
        CFG_OVERSAMPLE:  cfg_nxt.oversample_mode = cfg_data[1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.volume          <= '0;
      cfg_r.sixteen_bit     <= 1'b1;
      cfg_r.stereo          <= 1'b1;
      cfg_r.oversample_mode <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pgu_front #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_func  (in_tuser),
    .in_left  (in_tdata[15:0]),
    .in_right (in_tdata[31:16]),
    .in_index (in_tdata[40:32]),
    .in_value (in_tdata[56:41]),
    .q_pop    (q_pop),
    .q_push   (q_push),
    .q_data   (q_din)
  );

  pgu_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout),
    .full  (q_full)
  );

  pgu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_data     (q_dout),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_head_kept: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !q_pop |=> q_valid)
    else $error("queue head lost without pop");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> q_valid)
    else $error("pushed item missing from queue");

endmodule

`default_nettype wire

// ===== design/pgu_ram.sv =====
`default_nettype none

module pgu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 257
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

`default_nettype wire

// ===== design/pgu_front.sv =====
`default_nettype none

module pgu_front
  import pgu_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDefault,
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [15:0] in_left,
  input  wire logic [15:0] in_right,
  input  wire logic [8:0]  in_index,
  input  wire logic [15:0] in_value,
  input  wire logic        q_pop,
  output logic             q_push,
  output pair_t            q_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          accept;
  logic          sample_acc;
  logic          tab_we;
  logic [CW-1:0] credit_r;
  logic [CW-1:0] credit_nxt;
  logic          s1_v_r;
  logic          s2_v_r;
  logic          s3_v_r;
  logic          push_r;
  logic [15:0]   in_smp [2];
  logic [15:0]   x_r    [2];

  assign accept     = in_valid & in_ready;
  assign sample_acc = accept & ~in_func;
  assign tab_we     = accept & in_func & (32'(in_index) < 32'(TABLE_DEPTH));
  assign in_ready   = credit_r < CW'(QUEUE_DEPTH);
  assign in_smp[0]  = in_left;
  assign in_smp[1]  = in_right;

  // Credits cover the gain pipeline and the queue, so a push always finds room.
  always_comb begin
    credit_nxt = credit_r;
    unique case ({sample_acc, q_pop})
      2'b10:   credit_nxt = credit_r + CW'(1);
      2'b01:   credit_nxt = credit_r - CW'(1);
      default: credit_nxt = credit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      push_r   <= 1'b0;
    end else begin
      credit_r <= credit_nxt;
      s1_v_r   <= sample_acc;
      s2_v_r   <= s1_v_r;
      s3_v_r   <= s2_v_r;
      push_r   <= s3_v_r;
    end
  end

  for (genvar ch = 0; ch < 2; ch++) begin : g_lane
    logic [AW-1:0] rd_lo;
    logic [AW-1:0] rd_hi;
    logic [15:0]   tab_lo;
    logic [15:0]   tab_hi;
    logic [15:0]   s1_smp_r;
    logic [16:0]   diff;
    logic [25:0]   ip;
    logic [7:0]    abs8;
    logic [23:0]   mag;
    logic [15:0]   s2_smp_r;
    logic [15:0]   s2_lo_r;
    logic [25:0]   s2_ip_r;
    logic [23:0]   s2_mag_r;
    logic          s2_neg_r;
    logic [37:0]   recip;
    logic [15:0]   s3_smp_r;
    logic [15:0]   s3_g16_r;
    logic [9:0]    s3_q0_r;
    logic [23:0]   s3_mag_r;
    logic          s3_neg_r;
    logic [23:0]   rem;
    logic [10:0]   quo;
    logic [15:0]   g8;
    logic [15:0]   x_nxt;

    assign rd_lo = AW'({~in_smp[ch][15], in_smp[ch][14:8]});
    assign rd_hi = rd_lo + AW'(1);

    pgu_ram #(
      .WIDTH(16),
      .DEPTH(TABLE_DEPTH)
    ) u_tab (
      .clk     (clk),
      .we      (tab_we),
      .waddr   (AW'(in_index)),
      .wdata   (in_value),
      .raddr_a (rd_lo),
      .raddr_b (rd_hi),
      .rdata_a (tab_lo),
      .rdata_b (tab_hi)
    );

    always_comb begin
      diff = {tab_hi[15], tab_hi} - {tab_lo[15], tab_lo};
      ip   = 26'($signed(diff) * $signed({1'b0, s1_smp_r[7:0]}));
      abs8 = s1_smp_r[7] ? 8'(8'd0 - s1_smp_r[7:0]) : s1_smp_r[7:0];
      mag  = 24'(abs8) * 24'(cfg.volume);
    end

    // Division by 0x3fff: 16385 / 2^28 undershoots by at most one.
    always_comb begin
      recip = {s2_mag_r, 14'd0} + 38'(s2_mag_r);
      rem   = s3_mag_r - ({s3_q0_r, 14'd0} - 24'(s3_q0_r));
      quo   = 11'(s3_q0_r) + 11'(rem >= GainDiv);
      if (s3_neg_r) begin
        g8 = (quo > 11'd128) ? NegLimit : 16'(16'd0 - 16'(quo));
      end else begin
        g8 = (quo > 11'd127) ? PosLimit : 16'(quo);
      end
      if (cfg.volume <= UnityGain) begin
        x_nxt = s3_smp_r;
      end else if (cfg.sixteen_bit) begin
        x_nxt = s3_g16_r;
      end else begin
        x_nxt = g8;
      end
    end

    always_ff @(posedge clk) begin
      s1_smp_r <= cfg.sixteen_bit ? in_smp[ch] : {{8{in_smp[ch][7]}}, in_smp[ch][7:0]};
      s2_smp_r <= s1_smp_r;
      s2_lo_r  <= tab_lo;
      s2_ip_r  <= ip;
      s2_mag_r <= mag;
      s2_neg_r <= s1_smp_r[7];
      s3_smp_r <= s2_smp_r;
      s3_g16_r <= s2_lo_r + s2_ip_r[23:8];
      s3_q0_r  <= recip[37:28];
      s3_mag_r <= s2_mag_r;
      s3_neg_r <= s2_neg_r;
      x_r[ch]  <= x_nxt;
    end
  end

  assign q_push       = push_r;
  assign q_data.left  = x_r[0];
  assign q_data.right = x_r[1];

endmodule

`default_nettype wire

// ===== design/pgu_queue.sv =====
`default_nettype none

module pgu_queue
  import pgu_pkg::*;
#(
  parameter int DEPTH = QueueDepthDefault
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire pair_t din,
  input  wire logic  pop,
  output logic       valid,
  output pair_t      dout,
  output logic       full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  pair_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  assign valid = count_r != '0;
  assign full  = count_r == CW'(DEPTH);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== design/pgu_back.sv =====
`default_nettype none

module pgu_back
  import pgu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        q_valid,
  input  wire pair_t       q_data,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  output logic             out_tlast
);

  pair_t       hold_r [MaxRun];
  pair_t       run    [MaxRun];
  logic        hold_v_r;
  logic [1:0]  hold_k_r;
  logic [1:0]  hold_n_r;
  logic [1:0]  run_n;
  logic [15:0] last_left_r;
  logic [15:0] last_right_r;
  logic [15:0] m_l;
  logic [15:0] m_r;
  logic        out_v_r;
  pair_t       out_data_r;
  logic        out_last_r;
  logic        out_free;
  logic        emit;
  logic        emit_last;

  assign out_free  = ~out_v_r | out_tready;
  assign emit      = hold_v_r & out_free;
  assign emit_last = emit & (hold_k_r == hold_n_r);
  assign q_pop     = q_valid & (~hold_v_r | emit_last);

  always_comb begin
    m_l = pcm_mid(last_left_r, q_data.left, cfg.sixteen_bit);
    m_r = pcm_mid(last_right_r, q_data.right, cfg.sixteen_bit);
    for (int i = 0; i < MaxRun; i++) begin
      run[i] = '0;
    end
    unique case (cfg.oversample_mode)
      OsTwo: begin
        run[0].left  = m_l;
        run[0].right = m_r;
        run[1]       = q_data;
        run_n        = 2'd1;
      end
      OsFour: begin
        run[0].left  = pcm_mid(last_left_r, m_l, cfg.sixteen_bit);
        run[0].right = pcm_mid(last_right_r, m_r, cfg.sixteen_bit);
        run[1].left  = m_l;
        run[1].right = m_r;
        run[2].left  = pcm_mid(m_l, q_data.left, cfg.sixteen_bit);
        run[2].right = pcm_mid(m_r, q_data.right, cfg.sixteen_bit);
        run[3]       = q_data;
        run_n        = 2'd3;
      end
      default: begin
        run[0] = q_data;
        run_n  = 2'd0;
      end
    endcase
    if (!cfg.stereo) begin
      for (int i = 0; i < MaxRun; i++) begin
        run[i].right = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r     <= 1'b0;
      hold_k_r     <= '0;
      hold_n_r     <= '0;
      last_left_r  <= '0;
      last_right_r <= '0;
      out_v_r      <= 1'b0;
    end else begin
      if (q_pop) begin
        hold_v_r    <= 1'b1;
        hold_k_r    <= '0;
        hold_n_r    <= run_n;
        last_left_r <= q_data.left;
        if (cfg.stereo) begin
          last_right_r <= q_data.right;
        end
      end else if (emit_last) begin
        hold_v_r <= 1'b0;
      end else if (emit) begin
        hold_k_r <= hold_k_r + 2'd1;
      end
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < MaxRun; i++) begin
        hold_r[i] <= run[i];
      end
    end
    if (emit) begin
      out_data_r <= hold_r[hold_k_r];
      out_last_r <= hold_k_r == hold_n_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== test/pcm_gain_and_linear_upsampler_core_test.sv =====
`timescale 1ns / 1ps

module pcm_gain_and_linear_upsampler_core_test;
  import pgu_pkg::*;

  localparam int TABLE_DEPTH = 257;
  localparam int NUM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 7;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [15:0] PASS_LIMIT = 16'h3fff;
  localparam int GAIN_DIVISOR = 16383;
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TABLE = 1'b1;
  localparam logic [1:0] OS_NONE = 2'd0;
  localparam logic [1:0] OS_UNUSED = 2'd3;

  typedef struct {
    logic        func;
    logic [15:0] left;
    logic [15:0] right;
    logic [8:0]  tindex;
    logic [15:0] tvalue;
  } pcm_item_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic        last;
  } pcm_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = 64'd0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  pcm_gain_and_linear_upsampler_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pcm_item_t   pcm_items_to_send[$];
  pcm_result_t expected_outputs[$];
  pcm_item_t   item_on_bus;
  int          mismatches = 0;
  int          cycles = 0;
  bit          in_took = 1'b0;
  bit          out_took = 1'b0;
  bit          idle_en = 1'b1;
  bit          stall_en = 1'b1;
  int          in_gap = 0;
  int          out_stall = 0;

  logic [15:0] pr_volume = 16'd0;
  logic        pr_sixteen = 1'b1;
  logic        pr_stereo = 1'b1;
  logic [1:0]  pr_os = OS_NONE;
  int          last_l = 0;
  int          last_r = 0;
  int          gain_lut [0:TABLE_DEPTH-1];

  function automatic int read_sample(input logic [15:0] raw);
    logic signed [15:0] w;
    logic signed [7:0]  b;
    w = raw;
    b = raw[7:0];
    return pr_sixteen ? int'(w) : int'(b);
  endfunction

  function automatic int gain_sample(input int s);
    int g;
    int idx;
    int frac;
    int lo;
    int hi;
    logic signed [15:0] w;
    if (pr_volume <= PASS_LIMIT) begin
      return s;
    end
    if (!pr_sixteen) begin
      g = (s * int'(pr_volume)) / GAIN_DIVISOR;
      if (g < -128) begin
        g = -128;
      end
      if (g > 127) begin
        g = 127;
      end
      return g;
    end
    idx = ((s + 32768) >> 8) & 255;
    frac = s & 255;
    lo = gain_lut[idx];
    hi = gain_lut[idx + 1];
    g = lo + (((hi - lo) * frac) >>> 8);
    w = g[15:0];
    return int'(w);
  endfunction

  function automatic int midpoint(input int a, input int b);
    int m;
    logic signed [7:0] b8;
    m = a / 2 + b / 2;
    b8 = m[7:0];
    return pr_sixteen ? m : int'(b8);
  endfunction

  function automatic int run_value(input int prev, input int x, input int k);
    int m;
    m = midpoint(prev, x);
    case (pr_os)
      OsTwo: begin
        return (k == 0) ? m : x;
      end
      OsFour: begin
        case (k)
          0: return midpoint(prev, m);
          1: return m;
          2: return midpoint(m, x);
          default: return x;
        endcase
      end
      default: begin
        return x;
      end
    endcase
  endfunction

  task automatic predict_pcm_outputs(input pcm_item_t it);
    int l;
    int r;
    int n;
    int k;
    int v;
    pcm_result_t res;
    logic signed [15:0] tv;
    if (it.func == FUNC_TABLE) begin
      tv = it.tvalue;
      if (it.tindex < TABLE_DEPTH) begin
        gain_lut[it.tindex] = int'(tv);
      end
      return;
    end
    l = gain_sample(read_sample(it.left));
    r = pr_stereo ? gain_sample(read_sample(it.right)) : 0;
    n = (pr_os == OsTwo) ? 2 : (pr_os == OsFour) ? 4 : 1;
    for (k = 0; k < n; k++) begin
      v = run_value(last_l, l, k);
      res.left = v[15:0];
      v = pr_stereo ? run_value(last_r, r, k) : 0;
      res.right = v[15:0];
      res.last = (k == n - 1);
      expected_outputs.push_back(res);
    end
    last_l = l;
    if (pr_stereo) begin
      last_r = r;
    end
  endtask

  always @(posedge clk) begin
    in_took = rst_n && in_tvalid && in_tready;
    out_took = rst_n && out_tvalid && out_tready;
    if (in_took) begin
      predict_pcm_outputs(item_on_bus);
    end
    if (out_took) begin
      if (expected_outputs.size() == 0) begin
        $error("unexpected result: left_out %h right_out %h last_of_run %b",
               out_tdata[15:0], out_tdata[31:16], out_tlast);
        mismatches++;
      end else begin
        if (out_tdata[15:0] !== expected_outputs[0].left) begin
          $error("left_out: expected %h, actual %h", expected_outputs[0].left,
                 out_tdata[15:0]);
          mismatches++;
        end
        if (out_tdata[31:16] !== expected_outputs[0].right) begin
          $error("right_out: expected %h, actual %h", expected_outputs[0].right,
                 out_tdata[31:16]);
          mismatches++;
        end
        if (out_tlast !== expected_outputs[0].last) begin
          $error("last_of_run: expected %b, actual %b", expected_outputs[0].last,
                 out_tlast);
          mismatches++;
        end
        void'(expected_outputs.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pcm_items_to_send.size() != 0) begin
        item_on_bus = pcm_items_to_send.pop_front();
        in_tdata <= {7'd0, item_on_bus.tvalue, item_on_bus.tindex, item_on_bus.right,
                     item_on_bus.left};
        in_tuser <= item_on_bus.func;
        in_tvalid <= 1'b1;
        in_gap = idle_en ? $urandom_range(0, 5) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) begin
        out_stall = stall_en ? $urandom_range(0, 5) : 0;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_pair(input logic [15:0] l, input logic [15:0] r);
    pcm_item_t it;
    it.func = FUNC_SAMPLE;
    it.left = l;
    it.right = r;
    it.tindex = 9'($urandom);
    it.tvalue = 16'($urandom);
    pcm_items_to_send.push_back(it);
  endtask

  task automatic push_table(input logic [8:0] idx, input logic [15:0] val);
    pcm_item_t it;
    it.func = FUNC_TABLE;
    it.left = 16'($urandom);
    it.right = 16'($urandom);
    it.tindex = idx;
    it.tvalue = val;
    pcm_items_to_send.push_back(it);
  endtask

  task automatic wait_drained();
    while (pcm_items_to_send.size() != 0 || in_tvalid || expected_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The upper data bits of the narrow registers carry noise; only the low bits count.
  task automatic write_regs(input logic [15:0] vol, input logic six, input logic st,
                            input logic [1:0] os);
    logic [15:0] wdata [0:3];
    int k;
    wdata[CFG_VOLUME] = vol;
    wdata[CFG_SIXTEEN_BIT] = {15'($urandom), six};
    wdata[CFG_STEREO] = {15'($urandom), st};
    wdata[CFG_OVERSAMPLE] = {14'($urandom), os};
    wait_drained();
    for (k = 0; k < 4; k++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_t'(k);
      cfg_data <= wdata[k];
      @(posedge clk);
      while (!cfg_ready) begin
        @(posedge clk);
      end
      case (cfg_reg_t'(k))
        CFG_VOLUME: pr_volume = wdata[k];
        CFG_SIXTEEN_BIT: pr_sixteen = wdata[k][0];
        CFG_STEREO: pr_stereo = wdata[k][0];
        default: pr_os = wdata[k][1:0];
      endcase
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample(input logic sixteen);
    int c;
    logic [7:0] b;
    c = $urandom_range(0, 19);
    b = 8'($urandom);
    if (c == 0) begin
      return 16'h8000;
    end
    if (c == 1) begin
      return 16'h7fff;
    end
    if (!sixteen && c < 17) begin
      return {{8{b[7]}}, b};
    end
    return 16'($urandom);
  endfunction

  initial begin
    int i;
    int p;
    int c;
    logic [15:0] vol;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every entry is loaded before any gained sample can read the table.
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0) begin
        push_table(9'(i), 16'h8000);
      end else if (i == TABLE_DEPTH - 1) begin
        push_table(9'(i), 16'h7fff);
      end else begin
        push_table(9'(i), 16'($urandom));
      end
    end
    push_table(9'h1ff, 16'h1234);
    push_table(9'd257, 16'h5555);

    push_pair(16'h7fff, 16'h8000);
    push_pair(16'h8000, 16'h7fff);
    push_pair(16'h0000, 16'hffff);
    write_regs(16'h0000, 1'b1, 1'b1, OsTwo);
    push_pair(16'h0064, 16'hff9c);
    push_pair(16'h8000, 16'h7fff);
    write_regs(16'h0000, 1'b1, 1'b1, OsFour);
    push_pair(16'h7fff, 16'h8000);
    push_pair(16'h0001, 16'hffff);
    write_regs(16'h0000, 1'b1, 1'b1, OS_UNUSED);
    push_pair(16'h0005, 16'hfffb);
    write_regs(16'hffff, 1'b1, 1'b1, OsFour);
    push_pair(16'h8000, 16'h7fff);
    push_pair(16'hffff, 16'h00ff);
    push_pair(16'h0100, 16'hff00);
    write_regs(16'h4000, 1'b1, 1'b0, OsTwo);
    push_pair(16'h3039, 16'hcfc7);
    write_regs(16'h4000, 1'b0, 1'b1, OsFour);
    push_pair(16'h007f, 16'hff80);
    push_pair(16'h1234, 16'hff80);
    write_regs(16'hffff, 1'b0, 1'b1, OsTwo);
    push_pair(16'hff80, 16'h007f);
    push_pair(16'h0040, 16'hffc0);
    write_regs(16'h3fff, 1'b0, 1'b0, OS_NONE);
    push_pair(16'h7f80, 16'h1234);

    for (p = 0; p < NUM_PHASES; p++) begin
      case ($urandom_range(0, 4))
        0: vol = 16'h0000;
        1: vol = 16'h3fff;
        2: vol = 16'h4000;
        3: vol = 16'hffff;
        default: vol = 16'($urandom);
      endcase
      write_regs(vol, 1'($urandom), 1'($urandom), 2'($urandom));
      idle_en = ($urandom_range(0, 3) != 0);
      stall_en = ($urandom_range(0, 3) != 0);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        c = $urandom_range(0, 99);
        if (c < 3) begin
          push_table(9'($urandom_range(TABLE_DEPTH, 511)), 16'($urandom));
        end else if (c < 12) begin
          push_table(9'($urandom_range(0, TABLE_DEPTH - 1)), 16'($urandom));
        end else begin
          push_pair(pick_sample(pr_sixteen), pick_sample(pr_sixteen));
        end
      end
    end

    wait_drained();
    if (mismatches == 0 && expected_outputs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
